### rtl/core/cst_pkg.sv
// Shared types, character codes and name tables for the character stream tokenizer.
package cst_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_SPEC   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_COLON = 2'd1,
    PEND_MINUS = 2'd2
  } pend_t;

  typedef enum logic [4:0] {
    CL_IDENT   = 5'd0,
    CL_KEYWORD = 5'd1,
    CL_INTEGER = 5'd2,
    CL_TYPE    = 5'd3,
    CL_LPAREN  = 5'd4,
    CL_LBRACK  = 5'd5,
    CL_LBRACE  = 5'd6,
    CL_RPAREN  = 5'd7,
    CL_RBRACK  = 5'd8,
    CL_RBRACE  = 5'd9,
    CL_STAR    = 5'd10,
    CL_COMMA   = 5'd11,
    CL_COLON   = 5'd12,
    CL_DCOLON  = 5'd13,
    CL_ARROW   = 5'd14,
    CL_STRING  = 5'd15,
    CL_SPEC    = 5'd16
  } tok_class_t;

  // One result word held in the output buffer.
  typedef struct packed {
    logic       record;
    logic [7:0] text_byte;
    tok_class_t cls;
  } res_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Keywords occupy the low KEY_CNT match bits, type names the rest.
  localparam int NAME_CNT  = 12;
  localparam int KEY_CNT   = 7;
  localparam int NAME_BITS = 21 * 8;

  localparam logic [NAME_BITS-1:0] NAME_STR [NAME_CNT] = '{
    "__begin", "__end", "__module", {"__env_", "begin"}, {"__env_", "end"},
    {"__define_sector_", "begin"}, {"__define_sector_", "end"},
    "Int", "UInt", "String", "Image", "Font"
  };
  localparam int NAME_LEN [NAME_CNT] = '{7, 5, 8, 11, 9, 21, 19, 3, 4, 6, 5, 4};

  // Byte at position pos of fixed name idx; zero past the end.
  function automatic logic [7:0] name_char(input int idx, input int pos);
    logic [NAME_BITS-1:0] s;
    s = NAME_STR[idx];
    if (pos < NAME_LEN[idx]) begin
      return s[(NAME_LEN[idx] - 1 - pos) * 8 +: 8];
    end
    return 8'h00;
  endfunction

  // Token class of a single-byte punctuation token.
  function automatic tok_class_t punct_class(input logic [7:0] c);
    tok_class_t r;
    r = CL_COMMA;
    case (c)
      CH_LPAREN: r = CL_LPAREN;
      CH_LBRACK: r = CL_LBRACK;
      CH_LBRACE: r = CL_LBRACE;
      CH_RPAREN: r = CL_RPAREN;
      CH_RBRACK: r = CL_RBRACK;
      CH_RBRACE: r = CL_RBRACE;
      CH_STAR:   r = CL_STAR;
      default:   r = CL_COMMA;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/char_stream_tokenizer.sv
// Top level of the character stream tokenizer: byte decode, word classing, result buffer.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------------------
//   in      | to block  | in_valid/in_stall | kind, ch
//   out     | from block| out_valid/out_stall| record, text_byte, token_class, line_no,
//           |           |                   | col_no, last
//
// An input word is registered, decoded, and its results (zero to three) are
// loaded into a three-slot output buffer that drains one word per cycle while out is not
// stalled. The next byte is decoded once the buffer is empty or its last word is being taken,
// so a byte with several results holds the input while the single output port drains them.
// Reset (rst, synchronous) clears the input register, the buffer and all tokenizer state.
// A stall on out holds the buffer head; the input register fills and then stalls in.
module char_stream_tokenizer #(
  parameter int WORD_MAX   = 128,
  parameter int STRING_MAX = 512,
  parameter int SPEC_MAX   = 64,
  parameter int POS_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [7:0]            ch,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  record,
  output logic [7:0]            text_byte,
  output logic [4:0]            token_class,
  output logic [POS_WIDTH-1:0]  line_no,
  output logic [POS_WIDTH-1:0]  col_no,
  output logic                  last
);
  import cst_pkg::*;

  localparam int WL_W = $clog2(WORD_MAX);
  localparam int TL_W = $clog2((STRING_MAX > SPEC_MAX) ? STRING_MAX : SPEC_MAX);
  localparam logic [WL_W-1:0] WORD_LAST = WL_W'(WORD_MAX - 1);
  localparam logic [TL_W-1:0] STR_CAP   = TL_W'(STRING_MAX - 1);
  localparam logic [TL_W-1:0] SPEC_CAP  = TL_W'(SPEC_MAX - 1);
  localparam logic [POS_WIDTH-1:0] POS_TOP = '1;

  // Input register
  logic       in_full;
  logic       kind_q;
  logic [7:0] ch_q;

  // Tokenizer state
  logic [WL_W-1:0]      word_len;
  logic                 word_digits;
  logic [NAME_CNT-1:0]  word_match;
  mode_t                mode;
  pend_t                pending;
  logic [POS_WIDTH-1:0] line_count;
  logic [POS_WIDTH-1:0] col_count;
  logic [TL_W-1:0]      text_len;

  logic [WL_W-1:0]      word_len_next;
  logic                 word_digits_next;
  logic [NAME_CNT-1:0]  word_match_next;
  mode_t                mode_next;
  pend_t                pending_next;
  logic [POS_WIDTH-1:0] line_count_next;
  logic [POS_WIDTH-1:0] col_count_next;
  logic [TL_W-1:0]      text_len_next;

  // Output buffer: slot 0 is the head shown on the port
  res_t                 slot [3];
  logic [1:0]           rem;
  logic [POS_WIDTH-1:0] res_line;
  logic [POS_WIDTH-1:0] res_col;

  logic fire;
  logic in_take;
  logic out_take;

  // Decode flags
  logic       restart;
  logic       pend_en;
  tok_class_t pend_cls;
  logic       flush_req;
  logic       flush_en;
  logic       punct_en;
  tok_class_t punct_cls;
  logic       add_req;
  logic       add_en;
  logic       text_en;
  logic       newline;
  logic       tl_inc;
  logic       tl_clr;
  mode_t      mode_dec;
  pend_t      pend_dec;

  // Word classing
  logic [NAME_CNT-1:0] char_hit;
  logic [NAME_CNT-1:0] len_hit;
  logic                is_key;
  logic                is_type;
  tok_class_t          word_cls;

  res_t       entry [3];
  logic [1:0] entry_cnt;

  // Handshakes: process the registered byte once the buffer is empty or about to be
  assign out_take = out_valid && !out_stall;
  assign fire     = in_full && ((rem == 2'd0) || ((rem == 2'd1) && !out_stall));
  assign in_stall = in_full && !fire;
  assign in_take  = in_valid && !in_stall;

  // Per-name compares against the next word byte and the current length
  always_comb begin
    for (int i = 0; i < NAME_CNT; i++) begin
      char_hit[i] = (int'(word_len) < NAME_LEN[i]) && (name_char(i, int'(word_len)) == ch_q);
      len_hit[i]  = (int'(word_len) == NAME_LEN[i]);
    end
  end

  // Keyword beats integer beats type name
  assign is_key  = |(word_match[KEY_CNT-1:0] & len_hit[KEY_CNT-1:0]);
  assign is_type = |(word_match[NAME_CNT-1:KEY_CNT] & len_hit[NAME_CNT-1:KEY_CNT]);

  always_comb begin
    if (is_key) begin
      word_cls = CL_KEYWORD;
    end else if (word_digits) begin
      word_cls = CL_INTEGER;
    end else if (is_type) begin
      word_cls = CL_TYPE;
    end else begin
      word_cls = CL_IDENT;
    end
  end

  // Byte decode: which results this byte causes and where mode and pending go
  always_comb begin
    logic done;
    done      = 1'b0;
    restart   = 1'b0;
    pend_en   = 1'b0;
    pend_cls  = CL_COLON;
    flush_req = 1'b0;
    punct_en  = 1'b0;
    punct_cls = CL_COMMA;
    add_req   = 1'b0;
    newline   = 1'b0;
    tl_inc    = 1'b0;
    tl_clr    = 1'b0;
    mode_dec  = mode;
    pend_dec  = pending;
    if (kind_q) begin
      // End of input: close whatever is open, then return to reset values
      restart = 1'b1;
      if (mode == MODE_STRING) begin
        punct_en  = 1'b1;
        punct_cls = CL_STRING;
      end else if (mode == MODE_SPEC) begin
        punct_en  = 1'b1;
        punct_cls = CL_SPEC;
      end else begin
        pend_en   = (pending == PEND_COLON);
        flush_req = 1'b1;
      end
    end else if (mode != MODE_NORMAL) begin
      // Inside a string or spec every byte is content until the closer
      if (ch_q == ((mode == MODE_STRING) ? CH_QUOTE : CH_BAR)) begin
        punct_en  = 1'b1;
        punct_cls = (mode == MODE_STRING) ? CL_STRING : CL_SPEC;
        mode_dec  = MODE_NORMAL;
        tl_clr    = 1'b1;
      end else if (text_len < ((mode == MODE_STRING) ? STR_CAP : SPEC_CAP)) begin
        tl_inc = 1'b1;
      end
    end else begin
      pend_dec = PEND_NONE;
      if (pending == PEND_COLON) begin
        pend_en = 1'b1;
        if (ch_q == CH_COLON) begin
          pend_cls = CL_DCOLON;
          done     = 1'b1;
        end
      end else if ((pending == PEND_MINUS) && (ch_q == CH_GT)) begin
        flush_req = 1'b1;
        punct_en  = 1'b1;
        punct_cls = CL_ARROW;
        done      = 1'b1;
      end
      if (!done) begin
        case (ch_q) inside
          CH_CR: begin
          end
          CH_SP, CH_NL: begin
            flush_req = 1'b1;
            newline   = (ch_q == CH_NL);
          end
          CH_COLON: begin
            flush_req = 1'b1;
            pend_dec  = PEND_COLON;
          end
          CH_MINUS: begin
            pend_dec = PEND_MINUS;
          end
          CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_RPAREN, CH_RBRACK, CH_RBRACE,
          CH_STAR, CH_COMMA: begin
            flush_req = 1'b1;
            punct_en  = 1'b1;
            punct_cls = punct_class(ch_q);
          end
          CH_QUOTE: begin
            flush_req = 1'b1;
            mode_dec  = MODE_STRING;
            tl_clr    = 1'b1;
          end
          CH_BAR: begin
            flush_req = 1'b1;
            mode_dec  = MODE_SPEC;
            tl_clr    = 1'b1;
          end
          default: begin
            add_req = 1'b1;
          end
        endcase
      end
    end
  end

  assign flush_en = flush_req && (word_len != '0);
  assign add_en   = add_req && (word_len < WORD_LAST);
  assign text_en  = add_en || tl_inc;

  // Next state
  always_comb begin
    word_len_next    = word_len;
    word_digits_next = word_digits;
    word_match_next  = word_match;
    mode_next        = mode_dec;
    pending_next     = pend_dec;
    line_count_next  = line_count;
    col_count_next   = col_count;
    text_len_next    = text_len;

    if (restart || flush_req) begin
      word_len_next    = '0;
      word_digits_next = 1'b1;
      word_match_next  = '1;
    end else if (add_en) begin
      word_len_next    = word_len + 1'b1;
      word_digits_next = word_digits && (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
      word_match_next  = word_match & char_hit;
    end

    if (restart || tl_clr) begin
      text_len_next = '0;
    end else if (tl_inc) begin
      text_len_next = text_len + 1'b1;
    end

    if (restart) begin
      mode_next       = MODE_NORMAL;
      pending_next    = PEND_NONE;
      line_count_next = '0;
      col_count_next  = '0;
    end else if (newline) begin
      if (line_count != POS_TOP) begin
        line_count_next = line_count + 1'b1;
      end
      col_count_next = '0;
    end else if (col_count != POS_TOP) begin
      col_count_next = col_count + 1'b1;
    end
  end

  // Result words in order: pending colon, flushed word, punctuation, text byte
  always_comb begin
    logic [2:0] n;
    n = 3'd0;
    for (int k = 0; k < 3; k++) begin
      entry[k] = '{record: 1'b0, text_byte: 8'h00, cls: CL_IDENT};
    end
    if (pend_en) begin
      entry[n[1:0]] = '{record: 1'b1, text_byte: 8'h00, cls: pend_cls};
      n = n + 3'd1;
    end
    if (flush_en && (n < 3'd3)) begin
      entry[n[1:0]] = '{record: 1'b1, text_byte: 8'h00, cls: word_cls};
      n = n + 3'd1;
    end
    if (punct_en && (n < 3'd3)) begin
      entry[n[1:0]] = '{record: 1'b1, text_byte: 8'h00, cls: punct_cls};
      n = n + 3'd1;
    end
    if (text_en && (n < 3'd3)) begin
      entry[n[1:0]] = '{record: 1'b0, text_byte: ch_q, cls: CL_IDENT};
      n = n + 3'd1;
    end
    entry_cnt = n[1:0];
  end

  // Input register: take a byte whenever the decoder is free this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= kind;
      ch_q   <= ch;
    end
  end

  // Tokenizer state advances only when a byte is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      word_len    <= '0;
      word_digits <= 1'b1;
      word_match  <= '1;
      mode        <= MODE_NORMAL;
      pending     <= PEND_NONE;
      line_count  <= '0;
      col_count   <= '0;
      text_len    <= '0;
    end else if (fire) begin
      word_len    <= word_len_next;
      word_digits <= word_digits_next;
      word_match  <= word_match_next;
      mode        <= mode_next;
      pending     <= pending_next;
      line_count  <= line_count_next;
      col_count   <= col_count_next;
      text_len    <= text_len_next;
    end
  end

  // Output buffer: load on process, shift toward the head on each taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (fire) begin
      rem <= entry_cnt;
    end else if (out_take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot[0]  <= entry[0];
      slot[1]  <= entry[1];
      slot[2]  <= entry[2];
      res_line <= line_count;
      res_col  <= col_count;
    end else if (out_take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign out_valid   = (rem != 2'd0);
  assign last        = (rem == 2'd1);
  assign record      = slot[0].record;
  assign text_byte   = slot[0].text_byte;
  assign token_class = slot[0].cls;
  assign line_no     = res_line;
  assign col_no      = res_col;

`ifndef SYNTHESIS
  a_pend_normal_only: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_NORMAL) |-> (pending == PEND_NONE))
    else $error("pending byte held outside normal mode");

  a_text_len_idle: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_NORMAL) |-> (text_len == '0))
    else $error("text length nonzero in normal mode");

  a_word_len_cap: assert property (@(posedge clk) disable iff (rst)
    word_len <= WORD_LAST)
    else $error("word length beyond cap");

  a_empty_word_reset: assert property (@(posedge clk) disable iff (rst)
    (word_len == '0) |-> (word_digits && (word_match == '1)))
    else $error("empty word with stale match state");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    ((rem == 2'd1) && !out_stall && !fire) |=> (rem == 2'd0))
    else $error("last word taken but buffer not empty");
`endif

endmodule

### tb/sv/cst_token_checker.sv
`timescale 1ns / 100ps
// Channel monitor for the character stream tokenizer: predicts each result word and compares.
module cst_token_checker #(
  parameter int WORD_MAX   = 128,
  parameter int STRING_MAX = 512,
  parameter int SPEC_MAX   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  ch,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        record,
  input  logic [7:0]  text_byte,
  input  logic [4:0]  token_class,
  input  logic [15:0] line_no,
  input  logic [15:0] col_no,
  input  logic        last,
  output int          errors,
  output int          waiting
);
  import cst_pkg::*;

  localparam int          NAME_TOTAL  = 12;
  localparam int          KEYWORD_CNT = 7;
  localparam logic [15:0] POS_TOP     = 16'hFFFF;
  localparam int          REPORT_CAP  = 100;

  typedef struct packed {
    logic        record;
    logic [7:0]  text_byte;
    logic [4:0]  token_class;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic        last;
  } tok_word_t;

  // Scanner state.
  int unsigned wlen;
  bit          wdigits;
  logic [11:0] wmatch;
  mode_t       scan_mode;
  pend_t       pend;
  logic [15:0] line_cnt;
  logic [15:0] col_cnt;
  int unsigned tlen;
  logic [15:0] at_line;
  logic [15:0] at_col;

  tok_word_t   byte_results[$];
  tok_word_t   expected_words[$];

  function automatic string name_of(input int idx);
    string env_stem;
    string sector_stem;
    env_stem    = "__env_";
    sector_stem = "__define_sector_";
    case (idx)
      0:       return "__begin";
      1:       return "__end";
      2:       return "__module";
      3:       return {env_stem, "begin"};
      4:       return {env_stem, "end"};
      5:       return {sector_stem, "begin"};
      6:       return {sector_stem, "end"};
      7:       return "Int";
      8:       return "UInt";
      9:       return "String";
      10:      return "Image";
      default: return "Font";
    endcase
  endfunction

  task automatic add_result(input logic rec, input logic [7:0] b, input tok_class_t cls);
    tok_word_t w;
    w.record      = rec;
    w.text_byte   = b;
    w.token_class = cls;
    w.line_no     = at_line;
    w.col_no      = at_col;
    w.last        = 1'b0;
    byte_results.push_back(w);
  endtask

  task automatic clear_word();
    wlen    = 0;
    wdigits = 1'b1;
    wmatch  = '1;
  endtask

  task automatic clear_all();
    clear_word();
    scan_mode = MODE_NORMAL;
    pend      = PEND_NONE;
    line_cnt  = '0;
    col_cnt   = '0;
    tlen      = 0;
  endtask

  // Class the gathered word: keyword beats integer beats type name.
  task automatic close_word();
    int         i;
    bit         is_key;
    bit         is_type;
    string      nm;
    tok_class_t cls;
    is_key  = 1'b0;
    is_type = 1'b0;
    if (wlen == 0) return;
    for (i = 0; i < NAME_TOTAL; i++) begin
      nm = name_of(i);
      if (wmatch[i] && nm.len() == wlen) begin
        if (i < KEYWORD_CNT) is_key = 1'b1;
        else is_type = 1'b1;
      end
    end
    cls = CL_IDENT;
    if (is_key) cls = CL_KEYWORD;
    else if (wdigits) cls = CL_INTEGER;
    else if (is_type) cls = CL_TYPE;
    add_result(1'b1, 8'h00, cls);
    clear_word();
  endtask

  task automatic keep_byte(input logic [7:0] c);
    int    i;
    string nm;
    if (wlen >= WORD_MAX - 1) return;
    for (i = 0; i < NAME_TOTAL; i++) begin
      nm = name_of(i);
      if (!(wlen < nm.len() && nm[wlen] == c)) wmatch[i] = 1'b0;
    end
    if (c < CH_ZERO || c > CH_NINE) wdigits = 1'b0;
    wlen++;
    add_result(1'b0, c, CL_IDENT);
  endtask

  task automatic normal_byte(input logic [7:0] c);
    case (c)
      CH_CR: ;
      CH_SP, CH_NL: close_word();
      CH_COLON: begin
        close_word();
        pend = PEND_COLON;
      end
      CH_MINUS: pend = PEND_MINUS;
      CH_LPAREN: begin close_word(); add_result(1'b1, 8'h00, CL_LPAREN); end
      CH_LBRACK: begin close_word(); add_result(1'b1, 8'h00, CL_LBRACK); end
      CH_LBRACE: begin close_word(); add_result(1'b1, 8'h00, CL_LBRACE); end
      CH_RPAREN: begin close_word(); add_result(1'b1, 8'h00, CL_RPAREN); end
      CH_RBRACK: begin close_word(); add_result(1'b1, 8'h00, CL_RBRACK); end
      CH_RBRACE: begin close_word(); add_result(1'b1, 8'h00, CL_RBRACE); end
      CH_STAR:   begin close_word(); add_result(1'b1, 8'h00, CL_STAR); end
      CH_COMMA:  begin close_word(); add_result(1'b1, 8'h00, CL_COMMA); end
      CH_QUOTE: begin
        close_word();
        scan_mode = MODE_STRING;
        tlen      = 0;
      end
      CH_BAR: begin
        close_word();
        scan_mode = MODE_SPEC;
        tlen      = 0;
      end
      default: keep_byte(c);
    endcase
  endtask

  // Work out every result word one input word causes.
  task automatic tokenize(input logic k, input logic [7:0] c);
    bit          is_nl;
    bit          handled;
    logic [7:0]  closer;
    int unsigned cap;
    tok_word_t   w;
    is_nl   = 1'b0;
    handled = 1'b0;
    at_line = line_cnt;
    at_col  = col_cnt;
    if (k) begin
      if (scan_mode == MODE_STRING) begin
        add_result(1'b1, 8'h00, CL_STRING);
      end else if (scan_mode == MODE_SPEC) begin
        add_result(1'b1, 8'h00, CL_SPEC);
      end else begin
        if (pend == PEND_COLON) add_result(1'b1, 8'h00, CL_COLON);
        close_word();
      end
      clear_all();
    end else if (scan_mode != MODE_NORMAL) begin
      closer = (scan_mode == MODE_STRING) ? CH_QUOTE : CH_BAR;
      cap    = (scan_mode == MODE_STRING) ? STRING_MAX - 1 : SPEC_MAX - 1;
      if (c == closer) begin
        if (scan_mode == MODE_STRING) add_result(1'b1, 8'h00, CL_STRING);
        else add_result(1'b1, 8'h00, CL_SPEC);
        scan_mode = MODE_NORMAL;
        tlen      = 0;
      end else if (tlen < cap) begin
        add_result(1'b0, c, CL_IDENT);
        tlen++;
      end
    end else begin
      if (pend == PEND_COLON) begin
        pend = PEND_NONE;
        if (c == CH_COLON) begin
          add_result(1'b1, 8'h00, CL_DCOLON);
          handled = 1'b1;
        end else begin
          add_result(1'b1, 8'h00, CL_COLON);
        end
      end else if (pend == PEND_MINUS) begin
        pend = PEND_NONE;
        if (c == CH_GT) begin
          close_word();
          add_result(1'b1, 8'h00, CL_ARROW);
          handled = 1'b1;
        end
      end
      if (!handled) begin
        normal_byte(c);
        is_nl = (c == CH_NL);
      end
    end
    if (!k) begin
      if (is_nl) begin
        if (line_cnt != POS_TOP) line_cnt++;
        col_cnt = '0;
      end else if (col_cnt != POS_TOP) begin
        col_cnt++;
      end
    end
    if (byte_results.size() > 0) begin
      w      = byte_results.pop_back();
      w.last = 1'b1;
      byte_results.push_back(w);
    end
    while (byte_results.size() > 0) expected_words.push_back(byte_results.pop_front());
  endtask

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  task automatic check_word();
    tok_word_t w;
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: result word not expected, expected none, got record %0d byte %0d class %0d",
                 $time, record, text_byte, token_class);
      return;
    end
    w = expected_words.pop_front();
    check_field("record", 16'(w.record), 16'(record));
    check_field("text_byte", 16'(w.text_byte), 16'(text_byte));
    check_field("token_class", 16'(w.token_class), 16'(token_class));
    check_field("line_no", w.line_no, line_no);
    check_field("col_no", w.col_no, col_no);
    check_field("last", 16'(w.last), 16'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_all();
      expected_words.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) tokenize(kind, ch);
      if (out_valid && !out_stall) check_word();
    end
    waiting <= expected_words.size();
  end

endmodule

### tb/sv/char_stream_tokenizer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the character stream tokenizer: byte stimulus, back-pressure and verdict.
module char_stream_tokenizer_tb;
  import cst_pkg::*;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        kind      = 1'b0;
  logic [7:0]  ch        = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        record;
  logic [7:0]  text_byte;
  logic [4:0]  token_class;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic        last;

  int errors;
  int waiting;
  int sent    = 0;   // input words accepted so far
  int gap_pct = 0;   // chance in percent of an idle gap before an input word

  char_stream_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record      (record),
    .text_byte   (text_byte),
    .token_class (token_class),
    .line_no     (line_no),
    .col_no      (col_no),
    .last        (last)
  );

  cst_token_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record      (record),
    .text_byte   (text_byte),
    .token_class (token_class),
    .line_no     (line_no),
    .col_no      (col_no),
    .last        (last),
    .errors      (errors),
    .waiting     (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Keywords and type names the tokenizer knows; used to build near-miss words.
  function automatic string name_of(input int idx);
    string env_stem;
    string sector_stem;
    env_stem    = "__env_";
    sector_stem = "__define_sector_";
    case (idx)
      0:       return "__begin";
      1:       return "__end";
      2:       return "__module";
      3:       return {env_stem, "begin"};
      4:       return {env_stem, "end"};
      5:       return {sector_stem, "begin"};
      6:       return {sector_stem, "end"};
      7:       return "Int";
      8:       return "UInt";
      9:       return "String";
      10:      return "Image";
      default: return "Font";
    endcase
  endfunction

  // True for every byte that does something other than extend a word in normal mode.
  function automatic bit is_special(input logic [7:0] b);
    case (b)
      CH_NL, CH_CR, CH_SP, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_STAR, CH_COMMA, CH_MINUS,
      CH_COLON, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_BAR, CH_RBRACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Mostly letters, digits and underscore; now and then any other word byte (NUL, '>', 0xFF).
  function automatic logic [7:0] word_char();
    int         r;
    logic [7:0] b;
    r = $urandom_range(79, 0);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return CH_ZERO + 8'(r - 52);
    if (r < 66) return 8'h5F;
    do b = 8'($urandom_range(255, 0)); while (is_special(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(7, 0))
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      2:       return CH_LBRACE;
      3:       return CH_RPAREN;
      4:       return CH_RBRACK;
      5:       return CH_RBRACE;
      6:       return CH_STAR;
      default: return CH_COMMA;
    endcase
  endfunction

  // Offer one word on the input channel and hold it until the block takes it.
  task automatic send_word(input logic k, input logic [7:0] c);
    int gap;
    gap = 0;
    if ($urandom_range(99, 0) < gap_pct) begin
      gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // Flavor 0: word bytes, 1: decimal digits, 2: any byte but the closer.
  task automatic send_filler(input int n, input int flavor, input logic [7:0] closer);
    int         i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      if (flavor == 0) begin
        b = word_char();
      end else if (flavor == 1) begin
        b = CH_ZERO + 8'($urandom_range(9, 0));
      end else begin
        do b = 8'($urandom_range(255, 0)); while (b == closer);
      end
      send_word(1'b0, b);
    end
  endtask

  // End the current word by a delimiter, a carriage return (which does not end it) or end of input.
  task automatic end_word_input();
    case ($urandom_range(11, 0))
      0:       send_word(1'b1, 8'($urandom_range(255, 0)));
      1:       send_word(1'b0, CH_NL);
      2:       send_word(1'b0, CH_COMMA);
      3:       send_word(1'b0, CH_RPAREN);
      4:       send_word(1'b0, CH_LBRACK);
      5:       send_word(1'b0, CH_STAR);
      6:       send_word(1'b0, CH_COLON);
      7:       send_word(1'b0, CH_CR);
      8:       send_word(1'b0, CH_LBRACE);
      default: send_word(1'b0, CH_SP);
    endcase
  endtask

  // One random lexical unit: mostly well-formed tokens with random content, some noise.
  task automatic send_token();
    int         sel;
    string      w;
    logic [7:0] closer;
    if ($urandom_range(39, 0) == 0) begin
      case ($urandom_range(2, 0))
        0:       gap_pct = 0;
        1:       gap_pct = 25;
        default: gap_pct = 60;
      endcase
    end
    sel = $urandom_range(99, 0);
    if (sel < 14) begin
      // exact name, name cut short by one byte, or name with one extra byte
      w = name_of($urandom_range(11, 0));
      case ($urandom_range(3, 0))
        1:       w = w.substr(0, w.len() - 2);
        2:       w = {w, "s"};
        default: ;
      endcase
      send_text(w);
      end_word_input();
    end else if (sel < 24) begin
      send_filler($urandom_range(6, 1), 1, CH_SP);
      end_word_input();
    end else if (sel < 38) begin
      send_filler($urandom_range(8, 1), 0, CH_SP);
      end_word_input();
    end else if (sel < 48) begin
      send_word(1'b0, pick_punct());
    end else if (sel < 54) begin
      // colon, double colon, triple colon, optionally followed by a word byte
      repeat ($urandom_range(3, 1)) send_word(1'b0, CH_COLON);
      if ($urandom_range(1, 0) == 1) send_filler(1, 0, CH_SP);
    end else if (sel < 60) begin
      case ($urandom_range(5, 0))
        0: begin
          send_filler($urandom_range(4, 1), 0, CH_SP);
          send_text("->");
        end
        1: send_text("->");
        2: begin
          send_word(1'b0, CH_MINUS);
          send_filler(2, 0, CH_SP);
        end
        3: send_text("--");
        4: begin
          send_word(1'b0, CH_MINUS);
          send_word(1'b1, 8'($urandom_range(255, 0)));
        end
        default: send_text("-\n");
      endcase
    end else if (sel < 74) begin
      // string or spec; now and then left open
      closer = (sel < 68) ? CH_QUOTE : CH_BAR;
      send_word(1'b0, closer);
      send_filler($urandom_range(10, 0), 2, closer);
      if ($urandom_range(9, 0) != 0) send_word(1'b0, closer);
    end else if (sel < 84) begin
      case ($urandom_range(2, 0))
        0:       send_word(1'b0, CH_SP);
        1:       send_word(1'b0, CH_NL);
        default: send_word(1'b0, CH_CR);
      endcase
    end else if (sel < 88) begin
      send_word(1'b1, 8'($urandom_range(255, 0)));
    end else begin
      send_word(1'b0, 8'($urandom_range(255, 0)));
    end
  endtask

  // Stop offering and wait until every expected result word has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Output back-pressure: random stall runs, long free stretches, one long hold-off.
  initial begin
    int stall_left;
    int free_left;
    bit held_off;
    stall_left = 0;
    free_left  = 0;
    held_off   = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && sent >= 150) begin
        // hold off long enough for the result buffer to fill and stall the input
        held_off   = 1'b1;
        stall_left = 400;
        free_left  = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        if ($urandom_range(3, 0) == 0) begin
          stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3, 1);
        end else begin
          free_left = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 100)
                                                   : $urandom_range(12, 1);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  initial begin
    int goal;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, every punctuation, colon forms, arrow, lone minus,
    // carriage return inside a word, quote ending a word, newline and bar inside a string,
    // a spec, and a colon still pending at end of input.
    send_word(1'b0, 8'h00);     send_word(1'b0, 8'hFF);     send_word(1'b0, CH_GT);
    send_word(1'b0, CH_LPAREN); send_word(1'b0, CH_LBRACK); send_word(1'b0, CH_LBRACE);
    send_word(1'b0, CH_RPAREN); send_word(1'b0, CH_RBRACK); send_word(1'b0, CH_RBRACE);
    send_word(1'b0, CH_STAR);   send_word(1'b0, CH_COMMA);
    send_word(1'b0, CH_COLON);  send_word(1'b0, CH_COLON);
    send_word(1'b0, CH_COLON);  send_text("x");
    send_word(1'b0, CH_MINUS);  send_word(1'b0, CH_GT);
    send_word(1'b0, CH_MINUS);  send_text("y");             send_word(1'b0, CH_CR);
    send_word(1'b0, CH_QUOTE);  send_word(1'b0, CH_NL);     send_word(1'b0, CH_BAR);
    send_word(1'b0, CH_QUOTE);
    send_word(1'b0, CH_BAR);    send_text("a");             send_word(1'b0, CH_BAR);
    send_word(1'b0, CH_COLON);  send_word(1'b1, 8'hFF);
    drain();

    // Random token stream with idle gaps on both sides.
    gap_pct = 30;
    goal    = sent + 200;
    while (sent < goal) send_token();
    drain();

    // Long sizes: a word past its cap, specs at and past their cap.
    send_word(1'b1, 8'h00);
    send_filler(129, 0, CH_SP);
    send_word(1'b0, CH_SP);
    send_word(1'b0, CH_BAR);
    send_filler(63, 2, CH_BAR);
    send_word(1'b0, CH_BAR);
    send_word(1'b0, CH_BAR);
    send_filler(67, 2, CH_BAR);
    send_word(1'b1, 8'h00);
    drain();

    // Let any stray result words show up before the verdict.
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/cst_pkg.sv
rtl/core/char_stream_tokenizer.sv
tb/sv/cst_token_checker.sv
tb/sv/char_stream_tokenizer_tb.sv
